// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the byte FIFO RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checks that a property holds at every clock edge outside reset.
`define BF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define BF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define BF_ASSERT(label, prop, msg)
`define BF_ASSERT_IMP(label, ante, cons, msg)

`endif

`endif

// ----- rtl/core/bfifo_pkg.sv -----
// Shared types and constants of the byte ring FIFO.
package bfifo_pkg;

    localparam int CMD_W  = 2;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 11;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_PEEK  = 2'd2,
        CMD_SKIP  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RD,
        ST_DATA
    } state_t;

endpackage

// ----- rtl/core/bfifo_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module bfifo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/bfifo_addmod.sv -----
// Shared pointer adder: (a + b) modulo DEPTH, with a below DEPTH and b at most DEPTH.
module bfifo_addmod #(
    parameter int DEPTH = 1024
) (
    input  logic [$clog2(DEPTH)-1:0]   a,
    input  logic [$clog2(DEPTH+1)-1:0] b,
    output logic [$clog2(DEPTH)-1:0]   y
);

    localparam int PW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int SW = FW + 1;

    logic [SW-1:0] sum;
    logic [SW-1:0] wrapped;

    // The sum stays below twice DEPTH, so one conditional subtract wraps it.
    always_comb
    begin
        sum     = SW'(a) + SW'(b);
        wrapped = (sum >= SW'(DEPTH)) ? (sum - SW'(DEPTH)) : sum;
        y       = wrapped[PW-1:0];
    end

endmodule

// ----- rtl/core/byte_ring_fifo_with_peek_skip_top.sv -----
// Top level of the circular byte FIFO with read, peek and skip commands.
//
//  Channel  Direction  tdata (low bit up)                      tuser / tlast
//  s_axis   in         in_byte[7:0], amount[18:8], pad          tuser: command[1:0]
//  m_axis   out        out_byte[7:0], moved_count[18:8],        tuser: byte_valid[0],
//                      fill_level[29:19], pad                          accepted[1]
//                                                               tlast: last
//
// Every command is taken in the idle state and then executed by a small
// sequencer around one shared pointer adder (addition modulo DEPTH).
// A write or skip is executed in the EXEC state, which loads its result into
// the output register. For a read or peek, each byte passes through ST_RD,
// which reads the byte store through its registered read port, and ST_DATA,
// which moves the registered data into the output register. An empty read or
// peek is finished in the EXEC state like a write.
// The byte store needs no clearing after reset; the FIFO can accept its first
// transaction as soon as reset is released.
// A stalled output only holds the sequencer; the output register is freed in
// the same cycle in which the downstream side takes its transaction.

`include "assert_macros.svh"

module byte_ring_fifo_with_peek_skip_top #(
    parameter int DEPTH     = 1024,
    parameter int MAX_BURST = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // in_byte[7:0], amount[18:8]
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_byte[7:0], moved_count[18:8], fill_level[29:19]
    output logic [1:0]  m_axis_tuser,   // byte_valid[0], accepted[1]
    output logic        m_axis_tlast
);

    import bfifo_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int CW = (FW > CNT_W) ? FW : CNT_W;
    localparam int BW = $clog2(MAX_BURST + 1);
    localparam int SW = FW + 1;

    // Sequencer and command registers.
    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [BYTE_W-1:0]   byte_reg, byte_next;
    logic [CNT_W-1:0]    amount_reg, amount_next;

    // FIFO bookkeeping.
    logic [PW-1:0]       rp_reg, rp_next;
    logic [PW-1:0]       wp_reg, wp_next;
    logic [FW-1:0]       fill_reg, fill_next;

    // Burst walk.
    logic [PW-1:0]       addr_reg, addr_next;
    logic [BW-1:0]       rem_reg, rem_next;
    logic [CW-1:0]       n_reg, n_next;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic                out_bv_reg, out_bv_next;
    logic                out_last_reg, out_last_next;
    logic                out_acc_reg, out_acc_next;
    logic [CNT_W-1:0]    out_moved_reg, out_moved_next;
    logic [CNT_W-1:0]    out_fill_reg, out_fill_next;

    // Control.
    logic                s_fire;
    logic                out_free;
    logic                out_load;
    logic                ram_we;
    logic                ram_re;
    logic [BYTE_W-1:0]   ram_rdata;

    // Burst sizing.
    logic [CW-1:0]       amount_x;
    logic [CW-1:0]       fill_x;
    logic [CW-1:0]       n_skip;
    logic [CW-1:0]       n_burst;
    logic                full;
    logic                burst_cmd;
    logic                go_burst;

    // Shared adder.
    logic [PW-1:0]       unit_a;
    logic [FW-1:0]       unit_b;
    logic [PW-1:0]       unit_y;

    // Pointer consistency check.
    logic [SW-1:0]       ptr_sum;
    logic                ptr_ok;

    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        amount_x  = CW'(amount_reg);
        fill_x    = CW'(fill_reg);
        n_skip    = (amount_x < fill_x) ? amount_x : fill_x;
        n_burst   = (n_skip < CW'(MAX_BURST)) ? n_skip : CW'(MAX_BURST);
        full      = (fill_reg == FW'(DEPTH));
        burst_cmd = (cmd_reg == CMD_READ) || (cmd_reg == CMD_PEEK);
        go_burst  = burst_cmd && (n_burst != '0);
    end

    // Operand selection for the shared adder: the write pointer plus one, the
    // read pointer plus the skip count, or the burst address plus one.
    always_comb
    begin
        if (state_reg == ST_EXEC && cmd_reg == CMD_WRITE)
        begin
            unit_a = wp_reg;
        end
        else if (state_reg == ST_EXEC)
        begin
            unit_a = rp_reg;
        end
        else
        begin
            unit_a = addr_reg;
        end
        if (state_reg == ST_EXEC && cmd_reg == CMD_SKIP)
        begin
            unit_b = n_skip[FW-1:0];
        end
        else
        begin
            unit_b = FW'(1);
        end
    end

    bfifo_addmod #(
        .DEPTH (DEPTH)
    ) u_addmod (
        .a (unit_a),
        .b (unit_b),
        .y (unit_y)
    );

    bfifo_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (byte_reg),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (go_burst)
                begin
                    state_next = ST_RD;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD:
            begin
                state_next = ST_DATA;
            end
            ST_DATA:
            begin
                if (out_free)
                begin
                    state_next = (rem_reg == BW'(1)) ? ST_IDLE : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        s_axis_tready = 1'b0;
        ram_re        = 1'b0;
        ram_we        = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_EXEC:
            begin
                out_load = out_free && !go_burst;
                ram_we   = out_free && (cmd_reg == CMD_WRITE) && !full;
            end
            ST_RD:
            begin
                ram_re = 1'b1;
            end
            ST_DATA:
            begin
                out_load = out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Datapath updates.
    always_comb
    begin
        cmd_next       = cmd_reg;
        byte_next      = byte_reg;
        amount_next    = amount_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        addr_next      = addr_reg;
        rem_next       = rem_reg;
        n_next         = n_reg;
        out_byte_next  = out_byte_reg;
        out_bv_next    = out_bv_reg;
        out_last_next  = out_last_reg;
        out_acc_next   = out_acc_reg;
        out_moved_next = out_moved_reg;
        out_fill_next  = out_fill_reg;

        if (s_fire)
        begin
            cmd_next    = cmd_t'(s_axis_tuser[CMD_W-1:0]);
            byte_next   = s_axis_tdata[BYTE_W-1:0];
            amount_next = s_axis_tdata[BYTE_W+CNT_W-1:BYTE_W];
        end

        if (state_reg == ST_EXEC)
        begin
            if (go_burst)
            begin
                addr_next = rp_reg;
                rem_next  = n_burst[BW-1:0];
                n_next    = n_burst;
                if (cmd_reg == CMD_READ)
                begin
                    fill_next = fill_reg - n_burst[FW-1:0];
                end
            end
            else if (out_load)
            begin
                if (cmd_reg == CMD_WRITE && !full)
                begin
                    wp_next   = unit_y;
                    fill_next = fill_reg + FW'(1);
                end
                else if (cmd_reg == CMD_SKIP)
                begin
                    rp_next   = unit_y;
                    fill_next = fill_reg - n_skip[FW-1:0];
                end
                out_byte_next = '0;
                out_bv_next   = 1'b0;
                out_last_next = 1'b1;
                out_acc_next  = (cmd_reg == CMD_WRITE) && !full;
                if (cmd_reg == CMD_WRITE)
                begin
                    out_moved_next = CNT_W'(!full);
                end
                else if (cmd_reg == CMD_SKIP)
                begin
                    out_moved_next = n_skip[CNT_W-1:0];
                end
                else
                begin
                    out_moved_next = '0;
                end
                out_fill_next = CNT_W'(fill_next);
            end
        end

        if (state_reg == ST_DATA && out_load)
        begin
            out_byte_next  = ram_rdata;
            out_bv_next    = 1'b1;
            out_last_next  = (rem_reg == BW'(1));
            out_acc_next   = 1'b0;
            out_moved_next = n_reg[CNT_W-1:0];
            out_fill_next  = CNT_W'(fill_reg);
            addr_next      = unit_y;
            rem_next       = rem_reg - BW'(1);
            // The read pointer follows the burst only once it has finished.
            if (rem_reg == BW'(1) && cmd_reg == CMD_READ)
            begin
                rp_next = unit_y;
            end
        end
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rp_reg        <= '0;
            wp_reg        <= '0;
            fill_reg      <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        byte_reg      <= byte_next;
        amount_reg    <= amount_next;
        addr_reg      <= addr_next;
        n_reg         <= n_next;
        out_byte_reg  <= out_byte_next;
        out_bv_reg    <= out_bv_next;
        out_last_reg  <= out_last_next;
        out_acc_reg   <= out_acc_next;
        out_moved_reg <= out_moved_next;
        out_fill_reg  <= out_fill_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_fill_reg, out_moved_reg, out_byte_reg};
    assign m_axis_tuser  = {out_acc_reg, out_bv_reg};
    assign m_axis_tlast  = out_last_reg;

    // The write pointer equals the read pointer plus the fill count, modulo DEPTH.
    assign ptr_sum = SW'(rp_reg) + SW'(fill_reg);
    assign ptr_ok  = (ptr_sum == SW'(wp_reg)) || (ptr_sum == SW'(wp_reg) + SW'(DEPTH));

    // The fill count never exceeds the store depth.
    `BF_ASSERT(a_fill_bound, fill_reg <= FW'(DEPTH), "fill count exceeds depth")

    // Between commands the write pointer leads the read pointer by the fill count.
    `BF_ASSERT_IMP(a_ptr_fill, state_reg == ST_IDLE, ptr_ok, "pointers disagree with fill count")

    // A store read is only issued while bytes of the burst remain.
    `BF_ASSERT_IMP(a_burst_rem, state_reg == ST_RD || state_reg == ST_DATA, rem_reg != '0, "burst walk without remaining bytes")

endmodule
